@@ hdl/nel_pkg.sv @@
// Shared widths, register codes, record types and the saturating adder
// of the normalized Euclidean loss unit. Depends on nothing.
package nel_pkg;

    // Element and accumulator widths.
    localparam int DATA_WIDTH  = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int SUM_W       = 48;
    localparam int ACC_W       = 64;
    localparam int OUT_W       = 32;
    localparam int SQ_W        = 2 * DATA_WIDTH;
    localparam int ADD_W       = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

    // Configuration registers.
    localparam int SCALE_W    = 8;
    localparam int EPS_W      = 16;
    localparam int APB_W      = 32;
    localparam int REG_ADDR_W = 3;
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_EPS   = 1'b1;
    localparam logic [SCALE_W-1:0] SCALE_RST = 8'd24;
    localparam logic [EPS_W-1:0]   EPS_RST   = 16'd1;

    // Normaliser root and the weighting division.
    localparam int ROOT_SHIFT = 16;
    localparam int RAD_W      = SUM_W + ROOT_SHIFT;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int NUM_W      = SUM_W + SCALE_W;
    localparam int LOSS_FRAC  = 12;
    localparam int DIV_W      = OUT_W;
    localparam int DIV_HI_W   = NUM_W + LOSS_FRAC - DIV_W;

    // Queue between the accumulating front and the arithmetic back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // One finished sample as handed from front to back.
    typedef struct packed {
        logic [SUM_W-1:0] dsum;
        logic [SUM_W-1:0] refs;
        logic             batch_end;
    } t_sample;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Adds x to a sum and clamps the result at the sum's maximum.
    function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] s,
                                                     input logic [ADD_W-2:0] x);
        logic [ADD_W-1:0] t;
        t = ADD_W'(s) + ADD_W'(x);
        if (t > ADD_W'(SUM_MAX)) begin
            return SUM_MAX;
        end
        return t[SUM_W-1:0];
    endfunction

endpackage

@@ hdl/nel_front.sv @@
// Front part: takes element triples, squares the distances and keeps the
// per-sample sums. Depends on nel_pkg.
module nel_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [nel_pkg::DATA_WIDTH-1:0] i_pred_value,
    input  logic signed [nel_pkg::DATA_WIDTH-1:0] i_target_value,
    input  logic signed [nel_pkg::DATA_WIDTH-1:0] i_ref_value,
    input  logic                                i_sample_end,
    input  logic                                i_batch_end,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output nel_pkg::t_sample                    o_q_data
);

    localparam int DW = nel_pkg::DATA_WIDTH;

    logic            r_a_valid;
    logic [DW-1:0]   r_a_dp;
    logic [DW-1:0]   r_a_dr;
    logic            r_a_end;
    logic            r_a_bend;
    logic            r_b_valid;
    logic [nel_pkg::SQ_W-1:0] r_b_sqd;
    logic [nel_pkg::SQ_W-1:0] r_b_sqr;
    logic            r_b_end;
    logic            r_b_bend;
    logic [nel_pkg::SUM_W-1:0] r_dist;
    logic [nel_pkg::SUM_W-1:0] r_ref;

    logic            w_stall;
    logic            w_take;
    logic [DW:0]     w_dp;
    logic [DW:0]     w_dr;
    logic [DW:0]     w_dp_neg;
    logic [DW:0]     w_dr_neg;
    logic [nel_pkg::SUM_W-1:0] w_dist_new;
    logic [nel_pkg::SUM_W-1:0] w_ref_new;

    // The whole pipeline holds while a sample end waits for queue space.
    assign w_stall = r_b_valid && r_b_end && i_q_full;
    assign o_full  = w_stall;
    assign w_take  = i_push && !w_stall;

    // Differences one bit wider than the elements, then their magnitudes.
    assign w_dp = {i_pred_value[DW-1], i_pred_value} - {i_target_value[DW-1], i_target_value};
    assign w_dr = {i_ref_value[DW-1], i_ref_value} - {i_target_value[DW-1], i_target_value};
    assign w_dp_neg = -w_dp;
    assign w_dr_neg = -w_dr;

    // Stage A: magnitudes of the two distances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!w_stall) begin
            r_a_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_a_dp   <= w_dp[DW] ? w_dp_neg[DW-1:0] : w_dp[DW-1:0];
            r_a_dr   <= w_dr[DW] ? w_dr_neg[DW-1:0] : w_dr[DW-1:0];
            r_a_end  <= i_sample_end || i_batch_end;
            r_a_bend <= i_batch_end;
        end
    end

    // Stage B: squares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!w_stall) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_b_sqd  <= r_a_dp * r_a_dp;
            r_b_sqr  <= r_a_dr * r_a_dr;
            r_b_end  <= r_a_end;
            r_b_bend <= r_a_bend;
        end
    end

    // Stage C: saturating per-sample sums, handed on at the sample's end.
    assign w_dist_new = nel_pkg::sat_add_sum(r_dist, (nel_pkg::ADD_W-1)'(r_b_sqd));
    assign w_ref_new  = nel_pkg::sat_add_sum(r_ref, (nel_pkg::ADD_W-1)'(r_b_sqr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
            r_ref  <= '0;
        end else if (r_b_valid && !w_stall) begin
            if (r_b_end) begin
                r_dist <= '0;
                r_ref  <= '0;
            end else begin
                r_dist <= w_dist_new;
                r_ref  <= w_ref_new;
            end
        end
    end

    assign o_q_push           = r_b_valid && r_b_end && !i_q_full;
    assign o_q_data.dsum      = w_dist_new;
    assign o_q_data.refs      = w_ref_new;
    assign o_q_data.batch_end = r_b_bend;

`ifndef SYNTHESIS
    // A sample end held back by a full queue must still be there next cycle.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> (r_b_valid && r_b_end))
        else $error("front lost a stalled sample end");
`endif

endmodule

@@ hdl/nel_queue.sv @@
// Short queue of finished sample sums between front and back.
// Depends on nel_pkg.
module nel_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nel_pkg::t_sample   i_data,
    input  logic               i_pop,
    output nel_pkg::t_sample   o_head,
    output nel_pkg::t_q_status o_status
);

    nel_pkg::t_sample          r_mem [nel_pkg::QDEPTH];
    logic [nel_pkg::QPTR_W-1:0] r_wr;
    logic [nel_pkg::QPTR_W-1:0] r_rd;
    logic [nel_pkg::QPTR_W:0]   r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (nel_pkg::QPTR_W+1)'(nel_pkg::QDEPTH));

`ifndef SYNTHESIS
    // The fill level never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (nel_pkg::QPTR_W+1)'(nel_pkg::QDEPTH))
        else $error("sample queue overflow");
`endif

endmodule

@@ hdl/nel_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on nel_pkg.
module nel_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [nel_pkg::RAD_W-1:0]  i_radicand,
    output logic                       o_done,
    output logic [nel_pkg::ROOT_W-1:0] o_root
);

    localparam int RW    = nel_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW);

    logic                     r_busy;
    logic                     r_done;
    logic [nel_pkg::RAD_W-1:0] r_x;
    logic [RW+1:0]            r_rem;
    logic [RW-1:0]            r_root;
    logic [CNT_W-1:0]         r_cnt;

    logic [RW+3:0]            w_part;
    logic [RW+3:0]            w_trial;
    logic                     w_ge;
    logic [RW+3:0]            w_diff;

    // Bring down the next two radicand bits and try a one in the root.
    assign w_part  = {r_rem, r_x[nel_pkg::RAD_W-1 -: 2]};
    assign w_trial = (RW+4)'({r_root, 2'b01});
    assign w_ge    = (w_part >= w_trial);
    assign w_diff  = w_part - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(RW - 1);
            end else if (r_busy) begin
                r_x    <= {r_x[nel_pkg::RAD_W-3:0], 2'b00};
                r_rem  <= w_ge ? w_diff[RW+1:0] : w_part[RW+1:0];
                r_root <= {r_root[RW-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ hdl/nel_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on nel_pkg.
module nel_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nel_pkg::DIV_HI_W-1:0] i_hi,
    input  logic [nel_pkg::DIV_W-1:0]    i_lo,
    input  logic [nel_pkg::DIV_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [nel_pkg::DIV_W-1:0]    o_quot
);

    localparam int DW    = nel_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic             r_sat;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_lo;
    logic [DW-1:0]    r_q;
    logic [DW-1:0]    r_d;
    logic [CNT_W-1:0] r_cnt;

    logic [DW:0]      w_part;
    logic             w_ge;
    logic [DW:0]      w_diff;

    // Shift in the next dividend bit and try a subtraction.
    assign w_part = {r_rem, r_lo[DW-1]};
    assign w_ge   = (w_part >= {1'b0, r_d});
    assign w_diff = w_part - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // The quotient overflows when the upper part reaches the divisor or the divisor is zero.
                r_busy <= 1'b1;
                r_sat  <= (i_divisor == '0) ||
                          (i_hi >= nel_pkg::DIV_HI_W'(i_divisor));
                r_rem  <= i_hi[DW-1:0];
                r_lo   <= i_lo;
                r_d    <= i_divisor;
                r_q    <= '0;
                r_cnt  <= CNT_W'(DW - 1);
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_part[DW-1:0];
                r_lo  <= {r_lo[DW-2:0], 1'b0};
                r_q   <= {r_q[DW-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? '1 : r_q;

`ifndef SYNTHESIS
    // Without overflow the partial remainder stays below the divisor.
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_sat) |-> (r_rem < r_d))
        else $error("divider remainder out of range");
`endif

endmodule

@@ hdl/nel_back.sv @@
// Back part: per-sample normalising root, weighting division, batch
// accumulation and the result register. Depends on nel_pkg, nel_sqrt, nel_div.
module nel_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nel_pkg::t_q_status            i_q_status,
    input  nel_pkg::t_sample              i_head,
    output logic                          o_q_pop,
    input  logic [nel_pkg::SCALE_W-1:0]   i_scale,
    input  logic [nel_pkg::EPS_W-1:0]     i_epsilon,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [nel_pkg::OUT_W-1:0]     o_sample_loss,
    output logic [nel_pkg::OUT_W-1:0]     o_batch_loss,
    output logic                          o_batch_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_MUL,
        S_DIVL,
        S_ACC,
        S_DIVB,
        S_OUT
    } t_state;

    localparam int DVD_W = nel_pkg::NUM_W + nel_pkg::LOSS_FRAC;

    t_state                          r_state;
    nel_pkg::t_sample                r_rec;
    logic                            r_sqrt_go;
    logic                            r_div_go;
    logic [nel_pkg::ROOT_W-1:0]      r_root;
    logic [nel_pkg::NUM_W-1:0]       r_num;
    logic [nel_pkg::OUT_W-1:0]       r_loss;
    logic [nel_pkg::OUT_W-1:0]       r_bl;
    logic [nel_pkg::ACC_W-1:0]       r_acc;
    logic [nel_pkg::COUNT_WIDTH-1:0] r_count;
    logic                            r_out_valid;
    logic [nel_pkg::OUT_W-1:0]       r_out_sample;
    logic [nel_pkg::OUT_W-1:0]       r_out_batch;
    logic                            r_out_done;

    logic [nel_pkg::SUM_W-1:0]       w_r;
    logic [nel_pkg::RAD_W-1:0]       w_rad;
    logic                            w_sqrt_done;
    logic [nel_pkg::ROOT_W-1:0]      w_root;
    logic [DVD_W-1:0]                w_dvd;
    logic [nel_pkg::DIV_HI_W-1:0]    w_div_hi;
    logic [nel_pkg::DIV_W-1:0]       w_div_lo;
    logic [nel_pkg::DIV_W-1:0]       w_div_d;
    logic                            w_div_done;
    logic [nel_pkg::DIV_W-1:0]       w_quot;
    logic [nel_pkg::ACC_W:0]         w_acc_sum;

    // Normaliser r = ref_sum + epsilon, with 16 fraction bits added for the root.
    assign w_r   = nel_pkg::sat_add_sum(r_rec.refs, (nel_pkg::ADD_W-1)'(i_epsilon));
    assign w_rad = {w_r, {nel_pkg::ROOT_SHIFT{1'b0}}};

    nel_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_go),
        .i_radicand (w_rad),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // The divider serves the weighting first and the batch mean second.
    assign w_dvd    = {r_num, {nel_pkg::LOSS_FRAC{1'b0}}};
    assign w_div_hi = (r_state == S_DIVB) ?
                      nel_pkg::DIV_HI_W'(r_acc[nel_pkg::ACC_W-1:nel_pkg::DIV_W+1]) :
                      w_dvd[DVD_W-1:nel_pkg::DIV_W];
    assign w_div_lo = (r_state == S_DIVB) ? r_acc[nel_pkg::DIV_W:1] :
                      w_dvd[nel_pkg::DIV_W-1:0];
    assign w_div_d  = (r_state == S_DIVB) ? nel_pkg::DIV_W'(r_count) : r_root;

    nel_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_go),
        .i_hi      (w_div_hi),
        .i_lo      (w_div_lo),
        .i_divisor (w_div_d),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    assign w_acc_sum = {1'b0, r_acc} + (nel_pkg::ACC_W+1)'(r_loss);
    assign o_q_pop   = (r_state == S_IDLE) && !i_q_status.empty;

    // Sequencer for one finished sample, with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sqrt_go   <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_count     <= '0;
        end else begin
            r_sqrt_go <= 1'b0;
            r_div_go  <= 1'b0;
            // A taken result empties the register unless a new one replaces it.
            if (r_out_valid && i_pop && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_rec     <= i_head;
                        r_sqrt_go <= 1'b1;
                        r_state   <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_root  <= w_root;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num    <= r_rec.dsum * i_scale;
                    r_div_go <= 1'b1;
                    r_state  <= S_DIVL;
                end
                S_DIVL: begin
                    if (w_div_done) begin
                        // A zero normaliser gives zero only for a zero distance.
                        if ((r_root == '0) && (r_num == '0)) begin
                            r_loss <= '0;
                        end else begin
                            r_loss <= w_quot;
                        end
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc <= w_acc_sum[nel_pkg::ACC_W] ? '1 :
                             w_acc_sum[nel_pkg::ACC_W-1:0];
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (r_rec.batch_end) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIVB;
                    end else begin
                        r_bl    <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_DIVB: begin
                    if (w_div_done) begin
                        r_bl    <= w_quot;
                        r_acc   <= '0;
                        r_count <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_pop) begin
                        r_out_sample <= r_loss;
                        r_out_batch  <= r_bl;
                        r_out_done   <= r_rec.batch_end;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_sample_loss = r_out_sample;
    assign o_batch_loss  = r_out_batch;
    assign o_batch_done  = r_out_done;

`ifndef SYNTHESIS
    // The batch mean is only worked out for a sample that ends the batch.
    a_divb_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVB) |-> r_rec.batch_end)
        else $error("batch division without batch end");

    // A new result waits while the previous one has not been taken.
    a_out_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_pop) |=> (r_state == S_OUT))
        else $error("result register overwritten");
`endif

endmodule

@@ hdl/normalized_euclidean_loss_unit.sv @@
// Top level of the normalized Euclidean loss unit: configuration registers,
// front, sample queue and back. Depends on nel_pkg, nel_front, nel_queue, nel_back.
//
//  Channel   Handshake              Payload
//  input     i_push / o_full        pred, target, ref values, sample_end, batch_end
//  result    o_empty / i_pop        sample_loss, batch_loss, batch_done
//  config    psel, penable, pwrite  paddr, pwdata, prdata (pready tied high)
//
// Elements are accepted one per cycle while o_full is low; the front adds them in a
// three-stage pipeline. Each sample end holds the back for a root, a multiply, a divide
// and the hand-over of the result, and for a second divide when it also ends the batch.
// A four-sample queue decouples the two, so the input stalls only when the queue is full
// and another sample end is waiting to enter it. Reset is synchronous; it clears the
// sums, the batch count and the queue fill level, and restores the register defaults.
module normalized_euclidean_loss_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    output logic                                  o_full,
    input  logic signed [nel_pkg::DATA_WIDTH-1:0] i_pred_value,
    input  logic signed [nel_pkg::DATA_WIDTH-1:0] i_target_value,
    input  logic signed [nel_pkg::DATA_WIDTH-1:0] i_ref_value,
    input  logic                                  i_sample_end,
    input  logic                                  i_batch_end,
    output logic                                  o_empty,
    input  logic                                  i_pop,
    output logic [nel_pkg::OUT_W-1:0]             o_sample_loss,
    output logic [nel_pkg::OUT_W-1:0]             o_batch_loss,
    output logic                                  o_batch_done,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [nel_pkg::REG_ADDR_W-1:0]        paddr,
    input  logic [nel_pkg::APB_W-1:0]             pwdata,
    output logic [nel_pkg::APB_W-1:0]             prdata,
    output logic                                  pready
);

    logic [nel_pkg::SCALE_W-1:0] r_scale;
    logic [nel_pkg::EPS_W-1:0]   r_eps;

    logic               w_q_push;
    logic               w_q_pop;
    nel_pkg::t_sample   w_q_in;
    nel_pkg::t_sample   w_q_head;
    nel_pkg::t_q_status w_q_status;

    // Configuration registers, written on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= nel_pkg::SCALE_RST;
            r_eps   <= nel_pkg::EPS_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                nel_pkg::REG_SCALE: r_scale <= pwdata[nel_pkg::SCALE_W-1:0];
                nel_pkg::REG_EPS:   r_eps   <= pwdata[nel_pkg::EPS_W-1:0];
                default:            r_scale <= r_scale;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            nel_pkg::REG_SCALE: prdata = nel_pkg::APB_W'(r_scale);
            nel_pkg::REG_EPS:   prdata = nel_pkg::APB_W'(r_eps);
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    nel_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_pred_value   (i_pred_value),
        .i_target_value (i_target_value),
        .i_ref_value    (i_ref_value),
        .i_sample_end   (i_sample_end),
        .i_batch_end    (i_batch_end),
        .i_q_full       (w_q_status.full),
        .o_q_push       (w_q_push),
        .o_q_data       (w_q_in)
    );

    nel_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_data   (w_q_in),
        .i_pop    (w_q_pop),
        .o_head   (w_q_head),
        .o_status (w_q_status)
    );

    nel_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_head        (w_q_head),
        .o_q_pop       (w_q_pop),
        .i_scale       (r_scale),
        .i_epsilon     (r_eps),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_sample_loss (o_sample_loss),
        .o_batch_loss  (o_batch_loss),
        .o_batch_done  (o_batch_done)
    );

endmodule
